@@ hdl/chm_pkg.sv @@
// Shared constants, types and helpers for the chained hash map.
`timescale 1ns / 1ps

package chm_pkg;

    localparam int BUCKETS    = 128;   // power of two: bucket is key modulo BUCKETS
    localparam int ENTRIES    = 1024;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 12;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      next;
        logic                  next_vld;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_FIN
    } t_state;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_BITS-1:0] key);
        bucket_of = BKT_W'(key % BUCKETS);
    endfunction

endpackage

@@ hdl/chm_if.sv @@
// Request and response channel interfaces of the chained hash map.
`timescale 1ns / 1ps

interface chm_req_if
    import chm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

interface chm_rsp_if
    import chm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic                  full_res;

    modport source (output valid, found, value_out, full_res, input ready);
    modport sink   (input valid, found, value_out, full_res, output ready);
endinterface

@@ hdl/chained_hash_map_top.sv @@
// Top level of the chained hash map: sequencer over bucket-head and entry RAMs.
//
// Usage
//   i_req : request beats {func, key, value}; func 0 inserts or updates,
//           func 1 looks up. A beat is taken only while the sequencer is idle.
//   o_rsp : one response beat per request {found, value_out, full_res},
//           held in an output register until the sink takes it.
// Sequence
//   A request passes through the head state, which takes the bucket-head
//   RAM read, then the walk state, where each visited chain entry costs one
//   read of the single entry RAM, and the final state, which performs the
//   write-back and loads the response. An empty bucket skips the walk. The
//   entry-RAM read port, one entry per cycle, sets the walk rate. A new
//   request is accepted only after the final state of the last one.
//   Ready rises as soon as the response is loaded, even if that response is
//   still waiting at o_rsp.
// Reset
//   i_rst_n (synchronous, active low) clears the per-bucket valid flops, the
//   pool fill count and the sequencer; no clearing pass is needed, entries
//   above the fill count are never read.
// Back-pressure
//   If o_rsp is stalled when a second result is ready, the sequencer waits
//   in its final state with the write-back held off until the register frees.
`timescale 1ns / 1ps

module chained_hash_map_top
    import chm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp
);

    // sequencer and request registers
    t_state                r_state, n_state;
    logic                  r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [BKT_W-1:0]      r_bkt;
    logic                  r_hv;        // bucket had a head
    logic [IDX_W-1:0]      r_head;      // old head, next link of a new entry
    logic [IDX_W-1:0]      r_cur;       // entry under compare
    logic                  r_found;
    logic [CNT_W-1:0]      r_used;
    logic [BUCKETS-1:0]    r_head_vld;

    // response register
    logic                  r_ovalid;
    logic                  r_ofound;
    logic [VALUE_BITS-1:0] r_ovalue;
    logic                  r_ofull;

    // RAM ports
    logic                  head_we, head_re;
    logic [IDX_W-1:0]      head_rdata;
    logic                  ent_we, ent_re;
    logic [IDX_W-1:0]      ent_waddr, ent_raddr;
    t_entry                ent_wdata, ent_rdata;

    // decision terms
    logic req_fire, out_free, head_ok, key_hit, can_step, room;

    chm_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_bkt),
        .i_wdata (r_used[IDX_W-1:0]),
        .i_re    (head_re),
        .i_raddr (bucket_of(i_req.key)),
        .o_rdata (head_rdata)
    );

    chm_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign head_ok     = r_hv && (CNT_W'(head_rdata) < r_used);
    assign key_hit     = (ent_rdata.key == r_key);
    assign can_step    = ent_rdata.next_vld && (CNT_W'(ent_rdata.next) < r_used);
    assign room        = (r_used < CNT_W'(ENTRIES));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) n_state = S_HEAD;
            end
            S_HEAD: begin
                n_state = head_ok ? S_WALK : S_FIN;
            end
            S_WALK: begin
                if (key_hit || !can_step) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        head_re   = 1'b0;
        head_we   = 1'b0;
        ent_re    = 1'b0;
        ent_raddr = head_rdata;
        ent_we    = 1'b0;
        ent_waddr = r_cur;
        ent_wdata = '{key: r_key, value: r_value, next: ent_rdata.next,
                      next_vld: ent_rdata.next_vld};
        unique case (r_state)
            S_IDLE: begin
                head_re = req_fire;
            end
            S_HEAD: begin
                ent_re    = head_ok;
                ent_raddr = head_rdata;
            end
            S_WALK: begin
                ent_re    = !key_hit && can_step;
                ent_raddr = ent_rdata.next;
            end
            S_FIN: begin
                if (out_free && r_func == FUNC_INSERT) begin
                    if (r_found) begin
                        ent_we = 1'b1;       // value update in place
                    end else if (room) begin
                        ent_we    = 1'b1;    // new entry at the chain head
                        head_we   = 1'b1;
                        ent_waddr = r_used[IDX_W-1:0];
                        ent_wdata = '{key: r_key, value: r_value, next: r_head,
                                      next_vld: r_hv};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_head_vld <= '0;
            r_ovalid   <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            // S_FIN reloads the response register itself
            if (r_ovalid && o_rsp.ready && r_state != S_FIN) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_func  <= i_req.func;
                        r_key   <= i_req.key;
                        r_value <= i_req.value;
                        r_bkt   <= bucket_of(i_req.key);
                        r_hv    <= r_head_vld[bucket_of(i_req.key)];
                        r_found <= 1'b0;
                    end
                end
                S_HEAD: begin
                    r_head <= head_rdata;
                    r_cur  <= head_rdata;
                end
                S_WALK: begin
                    if (key_hit) r_found <= 1'b1;
                    else         r_cur   <= ent_rdata.next;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= r_found;
                        r_ofull  <= 1'b0;
                        if (r_func == FUNC_LOOKUP) begin
                            r_ovalue <= r_found ? ent_rdata.value : '0;
                        end else if (r_found || room) begin
                            r_ovalue <= r_value;
                        end else begin
                            r_ovalue <= '0;
                            r_ofull  <= 1'b1;
                        end
                        if (head_we) begin
                            r_head_vld[r_bkt] <= 1'b1;
                            r_used            <= r_used + CNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.found     = r_ofound;
    assign o_rsp.value_out = r_ovalue;
    assign o_rsp.full_res  = r_ofull;

    // pool fill never passes the pool size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(ENTRIES))
        else $error("fill count beyond pool size");

    // fill count only steps by one
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("fill count jumped");

    // chain walk stays inside the allocated part of the pool
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_re |-> (CNT_W'(ent_raddr) < r_used))
        else $error("entry read above fill count");

    // no entry read and write in the same cycle
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ent_re && ent_we))
        else $error("entry RAM read and write overlap");

    // a refused insert reports no hit and a zero value
    a_full_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofull) |-> (!r_ofound && r_ovalue == '0))
        else $error("full response carries data");

endmodule

@@ hdl/chm_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];   // holds between reads
        end
    end

    assign o_rdata = r_rdata;

endmodule
